>>> rtl/core/dda_line_rasterizer_top_macros.svh
// Assertion macros shared by the checker of the DDA line rasteriser.
`ifndef DDA_LINE_RASTERIZER_TOP_MACROS_SVH
`define DDA_LINE_RASTERIZER_TOP_MACROS_SVH

// Implication in the same cycle, ignored while reset is high.
`define DDA_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("DDA checker: same-cycle property failed");

// Implication into the following cycle, ignored while reset is high.
`define DDA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("DDA checker: next-cycle property failed");

// Implication into the following cycle that also holds across reset.
`define DDA_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("DDA checker: reset property failed");

`endif

>>> rtl/core/dda_pkg.sv
// Shared types and constants of the DDA line rasteriser.
`timescale 1ns / 1ps

package dda_pkg;

   localparam int COORD_BITS   = 11;
   localparam int FRAC_BITS    = 16;
   localparam int POS_BITS     = COORD_BITS + FRAC_BITS;
   localparam int STEP_BITS    = FRAC_BITS + 2;
   localparam int DIV_CNT_BITS = $clog2(FRAC_BITS + 1);
   localparam int QUEUE_DEPTH  = 2;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   localparam logic [POS_BITS-1:0] HALF_ULP = POS_BITS'(1) << (FRAC_BITS - 1);

   localparam logic OP_START = 1'b0;
   localparam logic OP_STEP  = 1'b1;

   typedef enum logic [1:0] {
      CMD_START,
      CMD_POINT,
      CMD_STEP
   } cmd_type;

   typedef enum logic {
      BACK_IDLE,
      BACK_DIVIDE
   } back_state_type;

   typedef struct packed {
      cmd_type                cmd;
      logic [COORD_BITS-1:0]  x_start;
      logic [COORD_BITS-1:0]  y_start;
      logic [COORD_BITS-1:0]  mag_x;
      logic [COORD_BITS-1:0]  mag_y;
      logic [COORD_BITS-1:0]  steps;
      logic                   neg_x;
      logic                   neg_y;
   } cmd_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

>>> rtl/core/dda_queue.sv
// Short request queue between the front and back parts of the rasteriser.
`timescale 1ns / 1ps

module dda_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  dda_pkg::cmd_entry_type    push_entry,
   input  logic                      pop,
   output dda_pkg::cmd_entry_type    head_entry,
   output dda_pkg::queue_status_type status
);

   dda_pkg::cmd_entry_type entries [dda_pkg::QUEUE_DEPTH];

   logic [dda_pkg::QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [dda_pkg::QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [dda_pkg::QUEUE_CNT_BITS-1:0] count_ff, count_in;
   logic                               do_push, do_pop;

   assign status.full  = (count_ff == dda_pkg::QUEUE_CNT_BITS'(dda_pkg::QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head_entry   = entries[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == dda_pkg::QUEUE_PTR_BITS'(dda_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == dda_pkg::QUEUE_PTR_BITS'(dda_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

>>> rtl/core/dda_front.sv
// Front part: accepts requests and classifies them for the back part.
`timescale 1ns / 1ps

module dda_front (
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_operation,
   input  logic [dda_pkg::COORD_BITS-1:0]      req_x_start,
   input  logic [dda_pkg::COORD_BITS-1:0]      req_y_start,
   input  logic [dda_pkg::COORD_BITS-1:0]      req_x_end,
   input  logic [dda_pkg::COORD_BITS-1:0]      req_y_end,
   input  dda_pkg::queue_status_type           queue_status,
   output logic                                push,
   output dda_pkg::cmd_entry_type              push_entry
);

   logic                           neg_x, neg_y;
   logic [dda_pkg::COORD_BITS-1:0] mag_x, mag_y, steps;

   assign req_ready = !queue_status.full;
   assign push      = req_valid && !queue_status.full;

   always_comb begin
      neg_x = (req_x_end < req_x_start);
      neg_y = (req_y_end < req_y_start);
      mag_x = neg_x ? (req_x_start - req_x_end) : (req_x_end - req_x_start);
      mag_y = neg_y ? (req_y_start - req_y_end) : (req_y_end - req_y_start);
      steps = (mag_x > mag_y) ? mag_x : mag_y;

      push_entry.x_start = req_x_start;
      push_entry.y_start = req_y_start;
      push_entry.mag_x   = mag_x;
      push_entry.mag_y   = mag_y;
      push_entry.steps   = steps;
      push_entry.neg_x   = neg_x;
      push_entry.neg_y   = neg_y;

      if (req_operation == dda_pkg::OP_STEP) begin
         push_entry.cmd = dda_pkg::CMD_STEP;
      end else if (steps == '0) begin
         push_entry.cmd = dda_pkg::CMD_POINT;
      end else begin
         push_entry.cmd = dda_pkg::CMD_START;
      end
   end

endmodule

>>> rtl/core/dda_back.sv
// Back part: increment divider, position accumulators and response register.
`timescale 1ns / 1ps

module dda_back (
   input  logic                            clock,
   input  logic                            reset,
   input  dda_pkg::cmd_entry_type          head_entry,
   input  dda_pkg::queue_status_type       queue_status,
   output logic                            pop,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [dda_pkg::COORD_BITS-1:0]  rsp_pixel_x,
   output logic [dda_pkg::COORD_BITS-1:0]  rsp_pixel_y,
   output logic                            rsp_pixel_valid,
   output logic                            rsp_last_pixel
);

   localparam int CB = dda_pkg::COORD_BITS;
   localparam int FB = dda_pkg::FRAC_BITS;
   localparam int PB = dda_pkg::POS_BITS;
   localparam int SB = dda_pkg::STEP_BITS;

   // One restoring division step: remainder stays below the divisor.
   function automatic logic [CB:0] div_iter(input logic [CB-1:0] rem,
                                            input logic [CB-1:0] divisor);
      logic [CB:0] shifted;
      logic [CB:0] diff;
      logic        ge;
      shifted = {rem, 1'b0};
      diff    = shifted - {1'b0, divisor};
      ge      = (shifted >= {1'b0, divisor});
      return ge ? {diff[CB-1:0], 1'b1} : {shifted[CB-1:0], 1'b0};
   endfunction

   function automatic logic [SB-1:0] make_step(input logic          full,
                                                input logic [FB-1:0] quot,
                                                input logic          neg);
      logic [SB-1:0] mag;
      mag = full ? (SB'(1) << FB) : {2'b00, quot};
      return neg ? (~mag + 1'b1) : mag;
   endfunction

   function automatic logic [PB-1:0] advance(input logic [PB-1:0] pos,
                                             input logic [SB-1:0] step);
      return pos + {{(PB - SB){step[SB-1]}}, step};
   endfunction

   function automatic logic [CB-1:0] round_pixel(input logic [PB-1:0] pos);
      logic [PB-1:0] sum;
      sum = pos + dda_pkg::HALF_ULP;
      return sum[PB-1:FB];
   endfunction

   dda_pkg::back_state_type state_ff, state_in;

   logic                           line_active_ff, line_active_in;
   logic [CB-1:0]                  steps_left_ff, steps_left_in;
   logic [PB-1:0]                  pos_x_ff, pos_x_in, pos_y_ff, pos_y_in;
   logic [SB-1:0]                  step_x_ff, step_x_in, step_y_ff, step_y_in;
   logic [CB-1:0]                  rem_x_ff, rem_x_in, rem_y_ff, rem_y_in;
   logic [FB-1:0]                  quot_x_ff, quot_x_in, quot_y_ff, quot_y_in;
   logic                           full_x_ff, full_x_in, full_y_ff, full_y_in;
   logic                           neg_x_ff, neg_x_in, neg_y_ff, neg_y_in;
   logic [CB-1:0]                  divisor_ff, divisor_in;
   logic [dda_pkg::DIV_CNT_BITS-1:0] div_cnt_ff, div_cnt_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [CB-1:0]                  rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic                           rsp_pv_ff, rsp_pv_in, rsp_last_ff, rsp_last_in;

   logic                           out_free;
   logic [CB:0]                    iter_x, iter_y;
   logic [FB-1:0]                  quot_x_next, quot_y_next;
   logic [PB-1:0]                  adv_x, adv_y;

   assign out_free        = !rsp_valid_ff || rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_x     = rsp_x_ff;
   assign rsp_pixel_y     = rsp_y_ff;
   assign rsp_pixel_valid = rsp_pv_ff;
   assign rsp_last_pixel  = rsp_last_ff;

   assign iter_x      = div_iter(rem_x_ff, divisor_ff);
   assign iter_y      = div_iter(rem_y_ff, divisor_ff);
   assign quot_x_next = {quot_x_ff[FB-2:0], iter_x[0]};
   assign quot_y_next = {quot_y_ff[FB-2:0], iter_y[0]};
   assign adv_x       = advance(pos_x_ff, step_x_ff);
   assign adv_y       = advance(pos_y_ff, step_y_ff);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dda_pkg::BACK_IDLE: begin
            if (pop && head_entry.cmd == dda_pkg::CMD_START) begin
               state_in = dda_pkg::BACK_DIVIDE;
            end
         end
         dda_pkg::BACK_DIVIDE: begin
            if (div_cnt_ff == dda_pkg::DIV_CNT_BITS'(1)) begin
               state_in = dda_pkg::BACK_IDLE;
            end
         end
         default: state_in = dda_pkg::BACK_IDLE;
      endcase
   end

   // Datapath and handshake outputs.
   always_comb begin
      pop            = 1'b0;
      line_active_in = line_active_ff;
      steps_left_in  = steps_left_ff;
      pos_x_in       = pos_x_ff;
      pos_y_in       = pos_y_ff;
      step_x_in      = step_x_ff;
      step_y_in      = step_y_ff;
      rem_x_in       = rem_x_ff;
      rem_y_in       = rem_y_ff;
      quot_x_in      = quot_x_ff;
      quot_y_in      = quot_y_ff;
      full_x_in      = full_x_ff;
      full_y_in      = full_y_ff;
      neg_x_in       = neg_x_ff;
      neg_y_in       = neg_y_ff;
      divisor_in     = divisor_ff;
      div_cnt_in     = div_cnt_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_x_in       = rsp_x_ff;
      rsp_y_in       = rsp_y_ff;
      rsp_pv_in      = rsp_pv_ff;
      rsp_last_in    = rsp_last_ff;

      unique case (state_ff)
         dda_pkg::BACK_IDLE: begin
            pop = !queue_status.empty && out_free;
            if (pop) begin
               rsp_valid_in = 1'b1;
               case (head_entry.cmd)
                  dda_pkg::CMD_STEP: begin
                     if (line_active_ff) begin
                        pos_x_in      = adv_x;
                        pos_y_in      = adv_y;
                        steps_left_in = steps_left_ff - 1'b1;
                        rsp_x_in      = round_pixel(adv_x);
                        rsp_y_in      = round_pixel(adv_y);
                        rsp_pv_in     = 1'b1;
                        rsp_last_in   = (steps_left_ff == CB'(1));
                        if (steps_left_ff == CB'(1)) begin
                           line_active_in = 1'b0;
                        end
                     end else begin
                        rsp_x_in    = '0;
                        rsp_y_in    = '0;
                        rsp_pv_in   = 1'b0;
                        rsp_last_in = 1'b0;
                     end
                  end
                  dda_pkg::CMD_POINT: begin
                     rsp_x_in       = head_entry.x_start;
                     rsp_y_in       = head_entry.y_start;
                     rsp_pv_in      = 1'b1;
                     rsp_last_in    = 1'b1;
                     line_active_in = 1'b0;
                     steps_left_in  = '0;
                  end
                  default: begin
                     rsp_x_in       = head_entry.x_start;
                     rsp_y_in       = head_entry.y_start;
                     rsp_pv_in      = 1'b1;
                     rsp_last_in    = 1'b0;
                     line_active_in = 1'b1;
                     steps_left_in  = head_entry.steps;
                     pos_x_in       = {head_entry.x_start, FB'(0)};
                     pos_y_in       = {head_entry.y_start, FB'(0)};
                     // A magnitude equal to the step count gives exactly one.
                     full_x_in      = (head_entry.mag_x == head_entry.steps);
                     full_y_in      = (head_entry.mag_y == head_entry.steps);
                     rem_x_in       = (head_entry.mag_x == head_entry.steps) ?
                                      '0 : head_entry.mag_x;
                     rem_y_in       = (head_entry.mag_y == head_entry.steps) ?
                                      '0 : head_entry.mag_y;
                     neg_x_in       = head_entry.neg_x;
                     neg_y_in       = head_entry.neg_y;
                     quot_x_in      = '0;
                     quot_y_in      = '0;
                     divisor_in     = head_entry.steps;
                     div_cnt_in     = dda_pkg::DIV_CNT_BITS'(FB);
                  end
               endcase
            end
         end
         dda_pkg::BACK_DIVIDE: begin
            rem_x_in   = iter_x[CB:1];
            rem_y_in   = iter_y[CB:1];
            quot_x_in  = quot_x_next;
            quot_y_in  = quot_y_next;
            div_cnt_in = div_cnt_ff - 1'b1;
            if (div_cnt_ff == dda_pkg::DIV_CNT_BITS'(1)) begin
               step_x_in = make_step(full_x_ff, quot_x_next, neg_x_ff);
               step_y_in = make_step(full_y_ff, quot_y_next, neg_y_ff);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= dda_pkg::BACK_IDLE;
         line_active_ff <= 1'b0;
         steps_left_ff  <= '0;
         div_cnt_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         line_active_ff <= line_active_in;
         steps_left_ff  <= steps_left_in;
         div_cnt_ff     <= div_cnt_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_x_ff    <= pos_x_in;
      pos_y_ff    <= pos_y_in;
      step_x_ff   <= step_x_in;
      step_y_ff   <= step_y_in;
      rem_x_ff    <= rem_x_in;
      rem_y_ff    <= rem_y_in;
      quot_x_ff   <= quot_x_in;
      quot_y_ff   <= quot_y_in;
      full_x_ff   <= full_x_in;
      full_y_ff   <= full_y_in;
      neg_x_ff    <= neg_x_in;
      neg_y_ff    <= neg_y_in;
      divisor_ff  <= divisor_in;
      rsp_x_ff    <= rsp_x_in;
      rsp_y_ff    <= rsp_y_in;
      rsp_pv_ff   <= rsp_pv_in;
      rsp_last_ff <= rsp_last_in;
   end

endmodule

>>> rtl/core/dda_line_rasterizer_top.sv
// Response path: an accepted request is first written into the queue, then loaded into the
// response register when the back part is idle and the output is free.
// Throughput: step requests flow at one per cycle while the back part is not dividing and
// the response is not stalled; a start request with non-zero length holds the back part
// while the restoring divider produces both increments, one quotient bit per cycle per axis.
// Reset: synchronous, active high; it empties the queue and clears the active line.
`timescale 1ns / 1ps

// Top level of the DDA line rasteriser.
//
// The front part computes the absolute coordinate differences and the step count
// of every incoming request and classifies it as a line start, a single-pixel
// line or a step. Classified requests wait in a two-entry queue, so that the
// front keeps accepting while the back part is busy dividing.
//
// The back part owns the line state. A line start emits the first endpoint at
// once and then runs a restoring divider for both axes in parallel, one bit per
// cycle; queued steps wait for it. A step adds the signed increments to the
// fixed-point positions and emits them rounded to nearest. A step with no active
// line returns an invalid, all-zero pixel. The response sits in an output
// register, so a new request is taken while the previous pixel is still held.
module dda_line_rasterizer_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_operation,
   input  logic [dda_pkg::COORD_BITS-1:0]      req_x_start,
   input  logic [dda_pkg::COORD_BITS-1:0]      req_y_start,
   input  logic [dda_pkg::COORD_BITS-1:0]      req_x_end,
   input  logic [dda_pkg::COORD_BITS-1:0]      req_y_end,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [dda_pkg::COORD_BITS-1:0]      rsp_pixel_x,
   output logic [dda_pkg::COORD_BITS-1:0]      rsp_pixel_y,
   output logic                                rsp_pixel_valid,
   output logic                                rsp_last_pixel
);

   dda_pkg::cmd_entry_type    push_entry;
   dda_pkg::cmd_entry_type    head_entry;
   dda_pkg::queue_status_type queue_status;
   logic                      push;
   logic                      pop;

   // Classification of incoming requests.
   dda_front u_front (
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operation (req_operation),
      .req_x_start   (req_x_start),
      .req_y_start   (req_y_start),
      .req_x_end     (req_x_end),
      .req_y_end     (req_y_end),
      .queue_status  (queue_status),
      .push          (push),
      .push_entry    (push_entry)
   );

   // Decoupling queue between the two parts.
   dda_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .status     (queue_status)
   );

   // Division, stepping and the response register.
   dda_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_entry      (head_entry),
      .queue_status    (queue_status),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_pixel_x     (rsp_pixel_x),
      .rsp_pixel_y     (rsp_pixel_y),
      .rsp_pixel_valid (rsp_pixel_valid),
      .rsp_last_pixel  (rsp_last_pixel)
   );

endmodule

>>> rtl/core/dda_checker.sv
// Port-level checker for the DDA line rasteriser, bound to the top level.
`timescale 1ns / 1ps
`include "dda_line_rasterizer_top_macros.svh"

module dda_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic [dda_pkg::COORD_BITS-1:0]      rsp_pixel_x,
   input logic [dda_pkg::COORD_BITS-1:0]      rsp_pixel_y,
   input logic                                rsp_pixel_valid,
   input logic                                rsp_last_pixel
);

   // No response may be pending straight after reset.
   `DDA_ASSERT_NEXT_ALWAYS(a_reset_clears, clock, reset, !rsp_valid)

   // A stalled response holds its payload.
   `DDA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_pixel_x) && $stable(rsp_pixel_y) &&
      $stable(rsp_pixel_valid) && $stable(rsp_last_pixel))

   // A step without a line returns an all-zero result.
   `DDA_ASSERT_SAME(a_idle_step_zero, clock, reset, rsp_valid && !rsp_pixel_valid,
      rsp_pixel_x == '0 && rsp_pixel_y == '0 && !rsp_last_pixel)

   // A response only appears after some request has been accepted; the check covers only the start after reset.
   `DDA_ASSERT_NEXT_ALWAYS(a_no_spurious, clock,
      reset || (!rsp_valid && !(req_valid && req_ready) && $past(reset)), !rsp_valid)

endmodule

bind dda_line_rasterizer_top dda_checker u_dda_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_pixel_x     (rsp_pixel_x),
   .rsp_pixel_y     (rsp_pixel_y),
   .rsp_pixel_valid (rsp_pixel_valid),
   .rsp_last_pixel  (rsp_last_pixel)
);
